// ===== hdl/fwxd_pkg.sv =====
// shared types and constants for the word xor descrambler
`timescale 1ns / 1ps
`default_nettype none
package fwxd_pkg;

   localparam int WORD_W       = 32;
   localparam int BLOCK_W      = 25;
   localparam int WIDX_W       = 5;
   localparam int CSR_IDX_W    = 3;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [WIDX_W-1:0] LAST_WORD_IDX = WIDX_W'(8'h20 - 8'd1);
   localparam int                BLOCK_SHIFT   = 7;   // 0x80 bytes per block

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IV0           = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IV1           = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IV2           = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IV3           = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LITTLE_ENDIAN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_START_BLOCK   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BLOCKS = 3'd6;

   // one classified word on its way from front to back
   typedef struct packed {
      logic [WORD_W-1:0] data;
      logic [WORD_W-1:0] key;
      logic [WORD_W-1:0] offset;
      logic              little_endian;
      logic              last;
   } fwxd_entry_type;

endpackage
`default_nettype wire

// ===== hdl/fwxd_front.sv =====
// front end: csr file, region tracking and key word generation
`timescale 1ns / 1ps
`default_nettype none
module fwxd_front
   import fwxd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_wdata,
   input  wire logic                 push,
   input  wire logic [WORD_W-1:0]    data_in,
   output fwxd_entry_type            entry
);

   logic [WORD_W-1:0]  iv_ff [4];
   logic [WORD_W-1:0]  iv_in [4];
   logic [WORD_W-1:0]  t0_ff, t0_in, t1_ff, t1_in;
   logic               le_ff, le_in;
   logic [BLOCK_W-1:0] start_ff, start_in;
   logic [BLOCK_W-1:0] region_ff, region_in;
   logic [WIDX_W-1:0]  widx_ff, widx_in;
   logic [WORD_W-1:0]  offset_ff, offset_in;
   logic [BLOCK_W-1:0] left_ff, left_in;

   logic [WORD_W-1:0]  tsel;
   logic [WORD_W-1:0]  ivsel;
   logic [WORD_W-1:0]  key;
   logic               last_block;
   logic               last;

   // key word for the current index
   always_comb begin
      unique case (widx_ff[1:0])
         2'd0:    tsel = t0_ff;
         2'd1:    tsel = t1_ff;
         2'd2:    tsel = ~t0_ff;
         default: tsel = ~t1_ff;
      endcase
      ivsel = iv_ff[widx_ff[4:3]];
      // t + iv - 1, or t - iv - 1 which is t + ~iv
      if (widx_ff[2]) key = tsel + ~ivsel;
      else            key = tsel + ivsel + {WORD_W{1'b1}};
   end

   assign last_block = (left_ff <= BLOCK_W'(1));
   assign last       = last_block && (widx_ff == LAST_WORD_IDX);

   always_comb begin
      entry.data          = data_in;
      entry.key           = key;
      entry.offset        = offset_ff;
      entry.little_endian = le_ff;
      entry.last          = last;
   end

   always_comb begin
      iv_in     = iv_ff;
      t0_in     = t0_ff;
      t1_in     = t1_ff;
      le_in     = le_ff;
      start_in  = start_ff;
      region_in = region_ff;
      widx_in   = widx_ff;
      offset_in = offset_ff;
      left_in   = left_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IV0: begin
               iv_in[0] = csr_wdata;
               t0_in    = csr_wdata - iv_ff[2] - WORD_W'(1);
            end
            CSR_IV1: begin
               iv_in[1] = csr_wdata;
               t1_in    = csr_wdata - iv_ff[3] - WORD_W'(1);
            end
            CSR_IV2: begin
               iv_in[2] = csr_wdata;
               t0_in    = iv_ff[0] - csr_wdata - WORD_W'(1);
            end
            CSR_IV3: begin
               iv_in[3] = csr_wdata;
               t1_in    = iv_ff[1] - csr_wdata - WORD_W'(1);
            end
            CSR_LITTLE_ENDIAN: le_in = csr_wdata[0];
            CSR_START_BLOCK: begin
               start_in  = csr_wdata[BLOCK_W-1:0];
               widx_in   = '0;
               offset_in = {csr_wdata[BLOCK_W-1:0], {BLOCK_SHIFT{1'b0}}};
               left_in   = region_ff;
            end
            CSR_REGION_BLOCKS: begin
               region_in = csr_wdata[BLOCK_W-1:0];
               widx_in   = '0;
               offset_in = {start_ff, {BLOCK_SHIFT{1'b0}}};
               left_in   = csr_wdata[BLOCK_W-1:0];
            end
            default: ;
         endcase
      end else if (push) begin
         if (widx_ff == LAST_WORD_IDX) begin
            widx_in = '0;
            if (last_block) begin
               offset_in = {start_ff, {BLOCK_SHIFT{1'b0}}};
               left_in   = region_ff;
            end else begin
               offset_in = offset_ff + (WORD_W'(1) << BLOCK_SHIFT);
               left_in   = left_ff - BLOCK_W'(1);
            end
         end else begin
            widx_in = widx_ff + WIDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) iv_ff[i] <= '0;
         t0_ff     <= {WORD_W{1'b1}};
         t1_ff     <= {WORD_W{1'b1}};
         le_ff     <= 1'b0;
         start_ff  <= '0;
         region_ff <= BLOCK_W'(1);
         widx_ff   <= '0;
         offset_ff <= '0;
         left_ff   <= BLOCK_W'(1);
      end else begin
         iv_ff     <= iv_in;
         t0_ff     <= t0_in;
         t1_ff     <= t1_in;
         le_ff     <= le_in;
         start_ff  <= start_in;
         region_ff <= region_in;
         widx_ff   <= widx_in;
         offset_ff <= offset_in;
         left_ff   <= left_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/fwxd_queue.sv =====
// short queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module fwxd_queue
   import fwxd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  fwxd_entry_type push_entry,
   output logic          full,
   input  wire logic     pop,
   output fwxd_entry_type head,
   output logic          empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   fwxd_entry_type     store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = store_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      if (do_pop)  rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      if (do_push && !do_pop)      cnt_in = cnt_ff + CNT_W'(1);
      else if (do_pop && !do_push) cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) store_ff[wr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/fwxd_back.sv =====
// back end: xor with key minus offset, byte order, result register
`timescale 1ns / 1ps
`default_nettype none
module fwxd_back
   import fwxd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  fwxd_entry_type   head,
   input  wire logic        q_empty,
   output logic             q_pop,
   input  wire logic        rsp_pop,
   output logic             rsp_empty,
   output logic [WORD_W-1:0] rsp_data_out,
   output logic             rsp_last_word
);

   function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   logic               valid_ff, valid_in;
   logic [WORD_W-1:0]  data_ff, data_in;
   logic               last_ff, last_in;
   logic [WORD_W-1:0]  mask;
   logic [WORD_W-1:0]  word;
   logic [WORD_W-1:0]  result;

   assign q_pop = !q_empty && (!valid_ff || rsp_pop);

   always_comb begin
      mask   = head.key - head.offset;
      word   = head.little_endian ? head.data : swap_bytes(head.data);
      word   = word ^ mask;
      result = head.little_endian ? word : swap_bytes(word);
   end

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (q_pop) begin
         valid_in = 1'b1;
         data_in  = result;
         last_in  = head.last;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_empty     = !valid_ff;
   assign rsp_data_out  = data_ff;
   assign rsp_last_word = last_ff;

endmodule
`default_nettype wire

// ===== hdl/firmware_word_xor_descrambler_top.sv =====
// top level of the firmware word xor descrambler
//
// usage
// - input side looks like a queue: drive req_data_in and raise req_push; a beat is
//   taken at a clock edge with req_push high and req_full low
// - result side looks like a queue: while rsp_empty is low the oldest result sits on
//   rsp_data_out / rsp_last_word and is taken at an edge with rsp_pop high
// - csr port: csr_we, csr_index, csr_wdata; a write lands at the edge, indexes 0..3 are
//   the iv words, 4 byte order, 5 start block, 6 region length; others are dropped
// - writing start block or region length re-arms the region at once
// - a beat accepted into the queue moves on into the result register once that register
//   is empty or being popped; one beat per cycle while req_full is low and rsp_pop stays
//   high; the back end has a single xor / subtract path, the front end a key adder
// - a queue of QUEUE_DEPTH_P beats sits between front and back; when the receiver stalls
//   the result register holds and the queue fills, then req_full rises
// - reset: iv words zero, big endian, start block 0, region length 1, queue and result
//   register empty; no clearing pass is needed
// - rsp_last_word marks the final word of the region; the next beat begins a new pass
`timescale 1ns / 1ps
`default_nettype none
module firmware_word_xor_descrambler_top
   import fwxd_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // input beats
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire logic [WORD_W-1:0]    req_data_in,
   // result beats
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output logic [WORD_W-1:0]         rsp_data_out,
   output logic                      rsp_last_word,
   // register writes
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_wdata
);

   fwxd_entry_type front_entry;
   fwxd_entry_type q_head;
   logic           accept;
   logic           q_empty;
   logic           q_pop;

   // a beat is taken only when the queue has room
   assign accept = req_push && !req_full;

   fwxd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push      (accept),
      .data_in   (req_data_in),
      .entry     (front_entry)
   );

   fwxd_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (front_entry),
      .full       (req_full),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   // back end drains the queue into the result register
   fwxd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (q_head),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_data_out  (rsp_data_out),
      .rsp_last_word (rsp_last_word)
   );

endmodule
`default_nettype wire
